@@ rtl/core/stream_pattern_replace_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stream pattern replace block
// Shared property forms, clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STREAM_PATTERN_REPLACE_DEFINES_SVH
`define STREAM_PATTERN_REPLACE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/spr_pkg.sv @@
// ----------------------------------------------------------------------------
// spr_pkg
// Types and constants shared by the pattern replace cells, output stage and top.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

  // Configuration port widths.
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned LenW = 4;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegPatLen = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPatBytes = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRepLen = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRepBytes = 3'd3;

  // Byte emitted at the end of every line.
  localparam logic [7:0] NewlineByte = 8'd10;

  // Control handed to every window cell.
  typedef struct packed {
    logic            shift;
    logic [LenW-1:0] plen;
  } spr_cell_ctrl_t;

  // One output word: a text byte and its last-of-run flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } spr_word_t;

endpackage

`default_nettype wire

@@ rtl/core/stream_pattern_replace.sv @@
// ----------------------------------------------------------------------------
// stream_pattern_replace
// Fixed-pattern search and replace on a byte stream, built as a chain of
// window cells, a burst register for multi-word runs and a skid output stage.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i / in_stall_o  char_byte_i, line_end_i
//  out      output     out_valid_o/out_stall_i  out_byte_o, run_last_o
//  cfg      input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// Plain text flows at one word per cycle unless the output stalls or a burst
// drains. A word that gives n > 1 output words (a replacement or a line flush)
// stalls the input while the burst register drains. An output stall reaches
// the input once the skid register fills and is lifted in the cycle after the
// output moves again; in_stall_o comes from flops only. Reset empties the
// window, the burst and the output stage and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stream_pattern_replace_defines.svh"

module stream_pattern_replace
  import spr_pkg::*;
#(
  parameter int unsigned PAT_MAX = 8,
  parameter int unsigned REP_MAX = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          char_byte_i,
  input  wire logic                line_end_i,
  // Output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [7:0]          out_byte_o,
  output logic                     run_last_o,
  // Configuration channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned ResMax = (PAT_MAX > REP_MAX) ? PAT_MAX : REP_MAX;
  localparam int unsigned CntW = $clog2(PAT_MAX + 1);
  localparam int unsigned NumW = $clog2(ResMax + 1);

  // Configuration registers.
  logic [LenW-1:0]      plen_q;
  logic [LenW-1:0]      rlen_q;
  logic [8*PAT_MAX-1:0] pattern_q;
  logic [8*REP_MAX-1:0] replace_q;
  logic                 cfg_we;
  logic [LenW-1:0]      plen_wr;
  logic [LenW-1:0]      rlen_wr;

  // Window state.
  logic [CntW-1:0]      count_q, count_d;
  spr_cell_ctrl_t       cell_ctrl;
  logic [7:0]           cell_in  [PAT_MAX];
  logic [7:0]           cell_out [PAT_MAX];
  logic [PAT_MAX-1:0]   cell_hit;
  logic                 match;
  logic                 full;

  // Result list of the accepted word.
  logic                 acc;
  logic [7:0]           res      [ResMax];
  logic [NumW-1:0]      res_n;

  // Burst register and output stage.
  logic [7:0]           burst_q  [ResMax];
  logic [7:0]           burst_d  [ResMax];
  logic [NumW-1:0]      left_q, left_d;
  logic                 up_ready;
  logic                 push;
  spr_word_t            push_word;
  spr_word_t            out_word;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Clamp the written lengths to the supported ranges.
  always_comb begin
    plen_wr = cfg_data_i[LenW-1:0];
    if (plen_wr == '0) begin
      plen_wr = 4'd1;
    end else if (plen_wr > LenW'(PAT_MAX)) begin
      plen_wr = LenW'(PAT_MAX);
    end
    rlen_wr = cfg_data_i[LenW-1:0];
    if (rlen_wr > LenW'(REP_MAX)) begin
      rlen_wr = LenW'(REP_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q    <= 4'd1;
      rlen_q    <= '0;
      pattern_q <= '0;
      replace_q <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        RegPatLen:   plen_q    <= plen_wr;
        RegPatBytes: pattern_q <= cfg_data_i[8*PAT_MAX-1:0];
        RegRepLen:   rlen_q    <= rlen_wr;
        RegRepBytes: replace_q <= cfg_data_i[8*REP_MAX-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input handshake: take a word only when the burst and the skid are empty.
  assign in_stall_o = (left_q != '0) || !up_ready;
  assign acc        = in_valid_i && !in_stall_o;

  // Window chain: cell 0 takes the new byte, each cell feeds the next.
  assign cell_ctrl.shift = acc && !line_end_i;
  assign cell_ctrl.plen  = plen_q;

  for (genvar j = 0; j < PAT_MAX; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cell_in[j] = char_byte_i;
    end else begin : g_link
      assign cell_in[j] = cell_out[j-1];
    end

    spr_cell #(
      .PAT_MAX (PAT_MAX),
      .IDX     (j)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .data_i    (cell_in[j]),
      .pattern_i (pattern_q),
      .data_o    (cell_out[j]),
      .hit_o     (cell_hit[j])
    );
  end

  assign match = &cell_hit;
  assign full  = (LenW'(count_q) + 4'd1 == plen_q);

  // Build the list of output words caused by the word on the input.
  always_comb begin
    for (int k = 0; k < ResMax; k++) begin
      res[k] = '0;
    end
    res_n = '0;
    if (line_end_i) begin
      // Flush oldest first, then the newline.
      for (int k = 0; k < ResMax; k++) begin
        for (int j = 0; j < PAT_MAX; j++) begin
          if (j + k + 1 == int'(count_q)) begin
            res[k] = cell_out[j];
          end
        end
        if (k == int'(count_q)) begin
          res[k] = NewlineByte;
        end
      end
      res_n = NumW'(count_q) + 1'b1;
    end else if (full && match) begin
      for (int k = 0; k < REP_MAX; k++) begin
        res[k] = replace_q[8*k +: 8];
      end
      res_n = NumW'(rlen_q);
    end else if (full) begin
      // Release the oldest byte, the one entering the last active cell.
      for (int j = 0; j < PAT_MAX; j++) begin
        if (LenW'(j) + 4'd1 == plen_q) begin
          res[0] = cell_in[j];
        end
      end
      res_n = NumW'(1);
    end
  end

  // Window fill count.
  always_comb begin
    count_d = count_q;
    if (cfg_we && (cfg_index_i == RegPatLen)) begin
      count_d = '0;
    end else if (acc) begin
      if (line_end_i || (full && match)) begin
        count_d = '0;
      end else if (full) begin
        count_d = CntW'(plen_q - 4'd1);
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  // Burst: the first word goes straight out, the rest wait here.
  always_comb begin
    push      = 1'b0;
    push_word = '0;
    left_d    = left_q;
    for (int k = 0; k < ResMax; k++) begin
      burst_d[k] = burst_q[k];
    end
    if (acc) begin
      push           = (res_n != '0);
      push_word.data = res[0];
      push_word.last = (res_n == NumW'(1));
      left_d         = (res_n != '0) ? res_n - 1'b1 : '0;
      for (int k = 0; k < ResMax - 1; k++) begin
        burst_d[k] = res[k+1];
      end
      burst_d[ResMax-1] = 8'd0;
    end else if ((left_q != '0) && up_ready) begin
      push           = 1'b1;
      push_word.data = burst_q[0];
      push_word.last = (left_q == NumW'(1));
      left_d         = left_q - 1'b1;
      for (int k = 0; k < ResMax - 1; k++) begin
        burst_d[k] = burst_q[k+1];
      end
      burst_d[ResMax-1] = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      left_q  <= '0;
    end else begin
      count_q <= count_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < ResMax; k++) begin
      burst_q[k] <= burst_d[k];
    end
  end

  // Output stage.
  spr_out_skid u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .ready_o (up_ready),
    .valid_o (out_valid_o),
    .word_o  (out_word),
    .stall_i (out_stall_i)
  );

  assign out_byte_o = out_word.data;
  assign run_last_o = out_word.last;

  // The window never holds a complete pattern between words.
  `SPR_ASSERT_NOW(a_count_below_plen, 1'b1, LenW'(count_q) < plen_q, "window count reached pattern length")
  // A line end always empties the window.
  `SPR_ASSERT_NEXT(a_line_end_clears, acc && line_end_i, count_q == '0, "window not empty after line end")
  // A draining burst loses exactly one word per free output slot.
  `SPR_ASSERT_NEXT(a_burst_drains, (left_q != '0) && up_ready, left_q == $past(left_q) - 1'b1, "burst did not drain by one word")

endmodule

`default_nettype wire

@@ rtl/core/spr_cell.sv @@
// ----------------------------------------------------------------------------
// spr_cell
// One window cell: holds one text byte, passes it to the next cell on a shift
// and compares the byte that enters it against its pattern position.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_cell
  import spr_pkg::*;
#(
  parameter int unsigned PAT_MAX = 8,
  parameter int unsigned IDX = 0
) (
  input  wire logic                   clk_i,
  input  wire spr_cell_ctrl_t         ctrl_i,
  input  wire logic [7:0]             data_i,
  input  wire logic [8*PAT_MAX-1:0]   pattern_i,
  output logic      [7:0]             data_o,
  output logic                        hit_o
);

  // The byte entering cell IDX arrived IDX words before the newest one; it
  // lines up with pattern byte plen-1-IDX when the window is full.
  localparam logic [LenW-1:0] CellPos = LenW'(IDX);

  logic [7:0] data_q;
  logic [7:0] pat_byte;
  logic       active;

  // Pick the pattern byte that faces this cell.
  always_comb begin
    pat_byte = '0;
    for (int i = 0; i < PAT_MAX; i++) begin
      if (LenW'(i) + CellPos + 4'd1 == ctrl_i.plen) begin
        pat_byte = pattern_i[8*i +: 8];
      end
    end
  end

  // A cell beyond the pattern length never blocks a match.
  assign active = (CellPos < ctrl_i.plen);
  assign hit_o  = !active || (data_i == pat_byte);

  // Byte store, moved along the chain on every accepted text byte.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ rtl/core/spr_out_skid.sv @@
// ----------------------------------------------------------------------------
// spr_out_skid
// Two-entry output stage: a main register and a skid register, so that the
// upstream ready is a flop and never waits on the downstream stall.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_out_skid
  import spr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire spr_word_t word_i,
  output logic           ready_o,
  output logic           valid_o,
  output spr_word_t      word_o,
  input  wire logic      stall_i
);

  logic      main_v_q, main_v_d;
  logic      skid_v_q, skid_v_d;
  spr_word_t main_q;
  spr_word_t skid_q;
  logic      take;

  // The main register may load when it is empty or its word leaves now.
  assign take = !main_v_q || !stall_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    if (take) begin
      main_v_d = skid_v_q || push_i;
      skid_v_d = 1'b0;
    end else if (push_i) begin
      skid_v_d = 1'b1;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take) begin
      main_q <= skid_v_q ? skid_q : word_i;
    end
    if (!take && push_i) begin
      skid_q <= word_i;
    end
  end

  assign ready_o = !skid_v_q;
  assign valid_o = main_v_q;
  assign word_o  = main_q;

endmodule

`default_nettype wire
